### hdl/hybrid_quicksort_insertion_core_assert.svh
// Assertion macros used by the checker file of the sort core.
`ifndef HYBRID_QUICKSORT_INSERTION_CORE_ASSERT_SVH
`define HYBRID_QUICKSORT_INSERTION_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HQI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define HQI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/hqi_pkg.sv
// Shared types and constants of the hybrid sort core.
package hqi_pkg;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CUTOFF_W = 7;
   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 7'd7;

   // Operation codes for the shared compare unit.
   typedef enum logic [0:0] {
      CMP_LT = 1'b0,
      CMP_GE = 1'b1
   } cmp_op_type;

   typedef struct packed {
      logic       start;
      cmp_op_type op;
   } cmp_ctl_type;
endpackage

### hdl/hqi_compare.sv
// Shared signed comparator, registered result.
module hqi_compare import hqi_pkg::*; (
   input  logic              clock,
   input  cmp_ctl_type       ctl,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output logic              result
);
   logic result_ff;
   logic result_in;

   always_comb begin
      case (ctl.op)
         CMP_LT:  result_in = $signed(a) < $signed(b);
         CMP_GE:  result_in = !($signed(a) < $signed(b));
         default: result_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

### hdl/hybrid_quicksort_insertion_core.sv
// Top level of the hybrid quicksort / insertion sort core.
// Usage:
// Elements enter on the req_ channel (req_value, req_last_item) with valid/ready.
// Loading takes one cycle per transfer. A transfer with req_last_item set
// starts the sort of all held elements (at most MAX_ELEMENTS, extras are
// dropped). The sort is Lomuto quicksort with last-element pivot and an
// explicit range stack; ranges no longer than the cutoff register are
// finished by insertion sort. Every comparison goes through one shared
// comparator with a registered result, and every element read goes
// through one memory read port. Each result is read out of the memory
// in the states ST_OUT_RD, ST_OUT_W and ST_OUT. Results leave on the
// rsp_ channel one per transfer, the last one marked with rsp_last_of_run.
// A stalled receiver holds the output register and the core simply waits;
// req_ready stays low from the final load until the last result has
// entered the output register. Reset clears the counts and returns the
// cutoff to 7. The element memory and the stack need no clearing pass.
module hybrid_quicksort_insertion_core import hqi_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_value,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_sorted_value,
   output logic                rsp_last_of_run,
   input  logic                csr_write_enable,
   input  logic [CUTOFF_W-1:0] csr_write_data
);
   localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

   typedef enum logic [4:0] {
      ST_LOAD, ST_POP, ST_POP_W, ST_RANGE,
      ST_IS_OUTER, ST_IS_RD, ST_IS_RDW, ST_IS_CMP, ST_IS_DEC,
      ST_PT_PIV, ST_PT_PIVW, ST_PT_RD, ST_PT_RDW, ST_PT_CMP, ST_PT_CMPW, ST_PT_SW1,
      ST_PT_FIN1, ST_PT_FIN2, ST_PT_PUSH,
      ST_SW_A, ST_SW_B,
      ST_OUT_RD, ST_OUT_W, ST_OUT
   } state_type;

   logic [DATA_W-1:0] mem [MAX_ELEMENTS];
   logic [2*AW-1:0]   stk [MAX_ELEMENTS];

   state_type     state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CUTOFF_W-1:0] cutoff_ff;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in, j_ff, j_in, st_ff, st_in;
   logic [DATA_W-1:0] a_ff, a_in, b_ff, b_in, piv_ff, piv_in;
   logic          valid_ff, valid_in, lastf_ff, lastf_in;
   logic [DATA_W-1:0] odata_ff, odata_in;
   logic [AW-1:0] raddr;
   logic [DATA_W-1:0] rdata_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic [DATA_W-1:0] wdata;
   logic          spush;
   logic [2*AW-1:0] sdata;
   logic [2*AW-1:0] stop_ff;
   cmp_ctl_type   cctl;
   logic [DATA_W-1:0] ca, cb;
   logic          cres;
   logic [AW:0]   rlen;

   hqi_compare u_cmp (.clock(clock), .ctl(cctl), .a(ca), .b(cb), .result(cres));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
      if (spush) begin
         stk[sp_ff[AW-1:0]] <= sdata;
      end
      stop_ff <= stk[sp_in[AW-1:0] - AW'(0)];
   end

   assign rlen = {1'b0, hi_ff} - {1'b0, lo_ff} + (AW+1)'(1);

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      count_in = count_ff; sp_in = sp_ff;
      lo_in = lo_ff; hi_in = hi_ff; i_in = i_ff; j_in = j_ff; st_in = st_ff;
      a_in = a_ff; b_in = b_ff; piv_in = piv_ff;
      valid_in = valid_ff; lastf_in = lastf_ff; odata_in = odata_ff;
      raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
      spush = 1'b0; sdata = '0;
      cctl.start = 1'b0; cctl.op = CMP_LT; ca = a_ff; cb = b_ff;
      if (rsp_valid && rsp_ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < MAX_CNT) begin
                  we = 1'b1; waddr = count_ff[AW-1:0]; wdata = req_value;
                  count_in = count_ff + CW'(1);
               end
               if (req_last_item) begin
                  if (count_in < CW'(2)) begin
                     i_in = '0; state_in = (count_in == '0) ? ST_LOAD : ST_OUT_RD;
                     if (count_in == '0) count_in = '0;
                  end else begin
                     spush = 1'b1; sdata = {AW'(0), AW'(count_in - CW'(1))};
                     sp_in = CW'(1); state_in = ST_POP_W;
                  end
               end
            end
         end
         ST_POP_W: begin
            state_in = ST_POP;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               i_in = '0; state_in = ST_OUT_RD;
            end else begin
               sp_in = sp_ff - CW'(1); state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            // The stack read of the new top settled during the pop cycle.
            lo_in = stop_ff[2*AW-1:AW]; hi_in = stop_ff[AW-1:0];
            state_in = ST_IS_OUTER; ret_in = ST_PT_PIV;
            i_in = stop_ff[2*AW-1:AW] + AW'(1);
            ret_in = ST_PT_PIV;
            state_in = ST_PT_FIN2; // decide in a cycle with lo/hi registered
         end
         ST_PT_FIN2: begin
            if ({1'b0, rlen} <= (AW+2)'(cutoff_ff) || cutoff_ff > CUTOFF_W'(MAX_ELEMENTS)) begin
               i_in = lo_ff + AW'(1); state_in = ST_IS_OUTER;
            end else begin
               state_in = ST_PT_PIV;
            end
         end
         ST_IS_OUTER: begin
            if ({1'b0, i_ff} > {1'b0, hi_ff} || i_ff == '0) begin
               state_in = ST_POP_W;
            end else begin
               j_in = i_ff; state_in = ST_IS_RD;
            end
         end
         ST_IS_RD: begin
            if (j_ff == lo_ff) begin
               i_in = i_ff + AW'(1); state_in = (i_ff == hi_ff) ? ST_POP_W : ST_IS_OUTER;
            end else begin
               raddr = j_ff; state_in = ST_IS_RDW;
            end
         end
         ST_IS_RDW: begin
            b_in = rdata_ff; raddr = j_ff - AW'(1); state_in = ST_IS_CMP;
         end
         ST_IS_CMP: begin
            a_in = rdata_ff;
            cctl.start = 1'b1; ca = b_ff; cb = rdata_ff;
            state_in = ST_IS_DEC;
         end
         ST_IS_DEC: begin
            if (cres) begin
               we = 1'b1; waddr = j_ff; wdata = a_ff;
               state_in = ST_SW_A;
               ret_in = ST_IS_RD;
            end else begin
               i_in = i_ff + AW'(1); state_in = (i_ff == hi_ff) ? ST_POP_W : ST_IS_OUTER;
            end
         end
         ST_SW_A: begin
            // Second half of the insertion swap: element b moves down one.
            we = 1'b1; waddr = j_ff - AW'(1); wdata = b_ff;
            j_in = j_ff - AW'(1); state_in = ret_ff;
         end
         ST_PT_PIV: begin
            raddr = hi_ff; state_in = ST_PT_PIVW;
         end
         ST_PT_PIVW: begin
            piv_in = rdata_ff; i_in = lo_ff; st_in = lo_ff; state_in = ST_PT_RD;
         end
         ST_PT_RD: begin
            if (i_ff == hi_ff) begin
               raddr = st_ff; state_in = ST_PT_FIN1;
            end else begin
               raddr = i_ff; state_in = ST_PT_RDW;
            end
         end
         ST_PT_RDW: begin
            a_in = rdata_ff; cctl.start = 1'b1; ca = rdata_ff; cb = piv_ff;
            raddr = st_ff; state_in = ST_PT_CMP;
         end
         ST_PT_CMP: begin
            b_in = rdata_ff; state_in = ST_PT_CMPW;
         end
         ST_PT_CMPW: begin
            if (cres) begin
               if (i_ff != st_ff) begin
                  we = 1'b1; waddr = st_ff; wdata = a_ff; state_in = ST_PT_SW1;
               end else begin
                  st_in = st_ff + AW'(1); i_in = i_ff + AW'(1); state_in = ST_PT_RD;
               end
            end else begin
               i_in = i_ff + AW'(1); state_in = ST_PT_RD;
            end
         end
         ST_PT_SW1: begin
            we = 1'b1; waddr = i_ff; wdata = b_ff;
            st_in = st_ff + AW'(1); i_in = i_ff + AW'(1); state_in = ST_PT_RD;
         end
         ST_PT_FIN1: begin
            // Keep the split point on the read port so its word is still there.
            raddr = st_ff;
            state_in = ST_SW_B;
         end
         ST_SW_B: begin
            // The displaced element goes to hi; the pivot goes to the split point in ST_PT_PUSH.
            we = 1'b1; waddr = hi_ff; wdata = rdata_ff; b_in = rdata_ff;
            state_in = ST_PT_PUSH; j_in = '0;
         end
         ST_PT_PUSH: begin
            if (j_ff == '0) begin
               we = 1'b1; waddr = st_ff; wdata = piv_ff; j_in = AW'(1);
               if ({1'b0, st_ff} > {1'b0, lo_ff} + (AW+1)'(1)) begin
                  spush = 1'b1; sdata = {lo_ff, st_ff - AW'(1)}; sp_in = sp_ff + CW'(1);
               end
            end else begin
               if ({1'b0, st_ff} + (AW+1)'(1) < {1'b0, hi_ff}) begin
                  spush = 1'b1; sdata = {st_ff + AW'(1), hi_ff}; sp_in = sp_ff + CW'(1);
               end
               state_in = ST_POP_W;
            end
         end
         ST_OUT_RD: begin
            raddr = i_ff; state_in = ST_OUT_W;
         end
         ST_OUT_W: begin
            raddr = i_ff; state_in = ST_OUT;
         end
         ST_OUT: begin
            raddr = i_ff;
            if (!valid_ff || rsp_ready) begin
               valid_in = 1'b1; odata_in = rdata_ff;
               lastf_in = ({1'b0, i_ff} + CW'(1)) == count_ff;
               if (({1'b0, i_ff} + CW'(1)) == count_ff) begin
                  count_in = '0; sp_in = '0; state_in = ST_LOAD;
               end else begin
                  i_in = i_ff + AW'(1); state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; ret_ff <= ST_IS_RD;
         count_ff <= '0; sp_ff <= '0; valid_ff <= 1'b0;
         cutoff_ff <= CUTOFF_RESET;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         count_ff <= count_in; sp_ff <= sp_in; valid_ff <= valid_in;
         if (csr_write_enable) begin
            cutoff_ff <= csr_write_data;
         end
      end
      lo_ff <= lo_in; hi_ff <= hi_in; i_ff <= i_in; j_ff <= j_in; st_ff <= st_in;
      a_ff <= a_in; b_ff <= b_in; piv_ff <= piv_in;
      lastf_ff <= lastf_in; odata_ff <= odata_in;
   end

   assign req_ready        = (state_ff == ST_LOAD);
   assign rsp_valid        = valid_ff;
   assign rsp_sorted_value = odata_ff;
   assign rsp_last_of_run  = lastf_ff;
endmodule

### hdl/hqi_checker.sv
// Port-level checker for the sort core, bound to the top level.
`include "hybrid_quicksort_insertion_core_assert.svh"
module hqi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_item,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sorted_value,
   input logic        rsp_last_of_run
);
   `HQI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sorted_value), "result changed under stall")
   `HQI_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last_item, !req_ready, "ready after final load")
   `HQI_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready || rsp_last_of_run, "loading while results pending")
endmodule

bind hybrid_quicksort_insertion_core hqi_checker u_hqi_checker (.*);

### tb/sv/tb_hybrid_quicksort_insertion_core.sv
// Self-checking testbench for the hybrid quicksort / insertion sort core.
`timescale 1ns / 100ps

module tb_hybrid_quicksort_insertion_core;
   import hqi_pkg::*;

   localparam int MAX_ELEMENTS = 64;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef struct {
      logic signed [31:0] sorted_value;
      logic               last_of_run;
   } sorted_word_type;

   // Tracks the held set, sorts it on the final transfer and checks the output.
   class sort_scoreboard;
      logic signed [31:0] held[MAX_ELEMENTS];
      int                 held_count;
      logic [6:0]         cutoff;
      sorted_word_type    pending[$];
      int                 mismatches;
      int                 runs;
      int                 checked;

      function new();
         held_count = 0;
         cutoff     = CUTOFF_RESET;
         mismatches = 0;
         runs       = 0;
         checked    = 0;
      endfunction

      function void swap_pair(int i, int j);
         logic signed [31:0] t;
         t = held[i];
         held[i] = held[j];
         held[j] = t;
      endfunction

      function void insertion_pass(int lo, int hi);
         int j;
         for (int i = lo + 1; i <= hi; i++) begin
            j = i;
            while (j > lo && held[j] < held[j-1]) begin
               swap_pair(j, j - 1);
               j--;
            end
         end
      endfunction

      function int lomuto_split(int lo, int hi);
         logic signed [31:0] pivot;
         int slot;
         pivot = held[hi];
         slot  = lo;
         for (int i = lo; i < hi; i++) begin
            if (held[i] < pivot) begin
               if (i != slot) swap_pair(i, slot);
               slot++;
            end
         end
         swap_pair(hi, slot);
         return slot;
      endfunction

      function void sort_held(int n);
         int lo_stk[MAX_ELEMENTS];
         int hi_stk[MAX_ELEMENTS];
         int depth;
         int lo;
         int hi;
         int p;
         if (n < 2) return;
         lo_stk[0] = 0;
         hi_stk[0] = n - 1;
         depth = 1;
         while (depth > 0) begin
            depth--;
            lo = lo_stk[depth];
            hi = hi_stk[depth];
            if (hi - lo + 1 <= cutoff) begin
               insertion_pass(lo, hi);
               continue;
            end
            p = lomuto_split(lo, hi);
            if (p > lo + 1 && depth < MAX_ELEMENTS) begin
               lo_stk[depth] = lo;
               hi_stk[depth] = p - 1;
               depth++;
            end
            if (p + 1 < hi && depth < MAX_ELEMENTS) begin
               lo_stk[depth] = p + 1;
               hi_stk[depth] = hi;
               depth++;
            end
         end
      endfunction

      function void note_element(logic signed [31:0] value, logic last_item);
         sorted_word_type w;
         if (held_count < MAX_ELEMENTS) begin
            held[held_count] = value;
            held_count++;
         end
         if (!last_item) return;
         sort_held(held_count);
         for (int k = 0; k < held_count; k++) begin
            w.sorted_value = held[k];
            w.last_of_run  = (k + 1 == held_count);
            pending.insert(pending.size(), w);
         end
         held_count = 0;
         runs++;
      endfunction

      function void check_word(logic signed [31:0] value, logic last_flag);
         sorted_word_type w;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result %0d last %0b", value, last_flag);
            return;
         end
         w = pending.pop_front();
         if (w.sorted_value !== value || w.last_of_run !== last_flag) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected %0d last %0b, got %0d last %0b",
                        w.sorted_value, w.last_of_run, value, last_flag);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_value;
   logic               req_last_item;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_sorted_value;
   logic               rsp_last_of_run;
   logic               csr_write_enable;
   logic [6:0]         csr_write_data;

   sort_scoreboard sorter;
   int  cycle_count;
   int  elements_sent;
   int  hold_off_cycles;
   bit  calm_output;
   bit  idle_input;

   hybrid_quicksort_insertion_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: checks each transfer and decides ready for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sorter.check_word(rsp_sorted_value, rsp_last_of_run);
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_output || ($urandom_range(99) >= 16);
         end
      end
   end

   // Valid stays high between back-to-back transfers and drops only for idling.
   task automatic send_element(logic signed [31:0] value, logic last_item);
      while (!idle_input && !calm_output && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_last_item <= last_item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sorter.note_element(value, last_item);
      elements_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sorter.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_cutoff(logic [6:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sorter.cutoff = value;
   endtask

   task automatic send_random_set(int n, int spread);
      logic signed [31:0] v;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: v = $urandom;
            1: v = $signed($urandom_range(spread)) - spread / 2;
            2: v = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: v = $signed($urandom_range(7));
         endcase
         send_element(v, i == n - 1);
      end
   endtask

   initial begin
      logic [6:0] cut_pick;
      sorter = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      req_last_item = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      cycle_count = 0;
      elements_sent = 0;
      hold_off_cycles = 0;
      calm_output = 1'b0;
      idle_input = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single element, extremes, descending run, duplicates.
      send_element(32'sh7fffffff, 1'b1);
      send_element(32'sh7fffffff, 1'b0);
      send_element(32'sh80000000, 1'b0);
      send_element(32'sh00000000, 1'b0);
      send_element(-32'sd1, 1'b0);
      send_element(32'sh55555555, 1'b0);
      send_element(32'shaaaaaaaa, 1'b1);
      write_cutoff(7'd0);
      for (int i = 0; i < 8; i++) send_element(8 - i, i == 7);
      for (int i = 0; i < 6; i++) send_element(3, i == 5);

      // Overfilled set: elements past the store size are dropped.
      write_cutoff(7'd127);
      send_random_set(66, 1000);
      write_cutoff(7'd64);
      send_random_set(64, 1 << 20);

      // Long receiver hold-off while a set loads and sorts.
      write_cutoff(7'd3);
      hold_off_cycles = 3000;
      send_random_set(20, 100);
      send_random_set(5, 100);

      // Sender pauses until all results are in.
      idle_input = 1'b0;
      wait_drained();

      while (elements_sent < 430) begin
         if ($urandom_range(4) == 0) begin
            cut_pick = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                : 7'($urandom_range(12));
            write_cutoff(cut_pick);
         end
         calm_output = (elements_sent > 300 && elements_sent < 360);
         send_random_set(($urandom_range(7) == 0) ? $urandom_range(33, 64)
                                                  : $urandom_range(1, 16),
                         $urandom_range(1, 200));
      end
      calm_output = 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);

      $display("Sorted %0d sets from %0d elements, %0d results checked.",
               sorter.runs, elements_sent, sorter.checked);
      $display("Cutoff ranged over 0 to 127, including full and overfilled sets.");
      if (sorter.mismatches == 0 && sorter.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing",
                  sorter.mismatches, sorter.pending.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
